// ===== rtl/tcs_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle contour segment package
// Request types and fixed widths shared by the contour segment datapath.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int COORD_W   = 16;
  localparam int VALUE_W   = 32;
  localparam int DIFF_W    = VALUE_W + 1;
  localparam int PROD_W    = COORD_W + DIFF_W;
  localparam int NUM_W     = PROD_W + 1;
  localparam int QUO_W     = COORD_W;
  localparam int DIV_STEPS = QUO_W;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [VALUE_W-1:0] vertex_a_value;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [VALUE_W-1:0] vertex_b_value;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic signed [VALUE_W-1:0] vertex_c_value;
  } tcs_in_t;

  typedef struct packed {
    logic                      segment_valid;
    logic                      along_edge;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } tcs_out_t;

endpackage

// ===== rtl/triangle_contour_segment.sv =====
// ----------------------------------------------------------------------------
// Triangle contour segment
// Iso-line segment of one triangle at a programmable contour level.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) takes one triangle per
// request. The result channel (out_valid, out_stall, out_data) returns exactly
// one result per triangle, in order, with segment_valid low when the triangle
// holds no segment. The contour level is written through cfg_valid, cfg_ready
// and cfg_data; the user must write it only while the block is idle, which the
// block itself does not enforce; cfg_ready is always high. A triangle accepted
// passes through one input stage, edge selection, multiply, sum and sign,
// sixteen stages of the pipelined dividers (one quotient bit each) and the
// output register. One triangle is accepted every cycle while the result side
// takes results. When the receiver stalls, the whole pipeline holds and
// in_stall is raised in the same cycle, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and sets the contour level to zero.
// ----------------------------------------------------------------------------
module triangle_contour_segment
  import tcs_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tcs_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tcs_out_t                  out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic signed [VALUE_W-1:0] cfg_data
);

  typedef struct packed {
    logic                      seg;
    logic                      along;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
  } meta_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [DIFF_W-1:0]  dq;
    logic signed [DIFF_W-1:0]  dp;
    logic signed [DIFF_W-1:0]  dd;
  } cross_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] qx;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] qy;
    logic signed [DIFF_W-1:0] dd;
  } prod_t;

  logic                      en;
  logic signed [VALUE_W-1:0] level_r;

  logic                      s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic [DIV_STEPS-1:0]      div_vld_r;
  logic                      out_valid_r;
  tcs_out_t                  out_data_r;

  tcs_in_t                   s1_item_r;
  logic signed [VALUE_W-1:0] s1_level_r;
  meta_t                     s2_meta_r, s3_meta_r, s4_meta_r;
  meta_t                     div_meta_r [DIV_STEPS];
  cross_t                    s2_cr_r [2];
  prod_t                     s3_pr_r [2];
  logic [NUM_W-1:0]          s4_nmag_r [4];
  logic [DIFF_W-1:0]         s4_dmag_r [4];
  logic                      s4_neg_r [4];

  meta_t                     s2_meta_nxt;
  cross_t                    s2_cr_nxt [2];
  logic [NUM_W-1:0]          s4_nmag_nxt [4];
  logic [DIFF_W-1:0]         s4_dmag_nxt [4];
  logic                      s4_neg_nxt [4];
  logic signed [QUO_W-1:0]   quo [4];
  tcs_out_t                  out_data_nxt;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Edge selection.
  always_comb begin
    logic signed [VALUE_W-1:0] vv [3];
    logic signed [COORD_W-1:0] xx [3];
    logic signed [COORD_W-1:0] yy [3];
    logic signed [VALUE_W-1:0] emin [3];
    logic signed [VALUE_W-1:0] emax [3];
    logic                      on_e [3];
    logic                      cr_e [3];
    logic signed [VALUE_W-1:0] lo, hi, lv;
    logic                      nfound, stop;
    logic [1:0]                c [2];
    logic [1:0]                cn [2];
    logic [1:0]                ea, eb;
    int                        b;
    vv[0] = s1_item_r.vertex_a_value;
    vv[1] = s1_item_r.vertex_b_value;
    vv[2] = s1_item_r.vertex_c_value;
    xx[0] = s1_item_r.vertex_a_x;
    xx[1] = s1_item_r.vertex_b_x;
    xx[2] = s1_item_r.vertex_c_x;
    yy[0] = s1_item_r.vertex_a_y;
    yy[1] = s1_item_r.vertex_b_y;
    yy[2] = s1_item_r.vertex_c_y;
    lv = s1_level_r;
    lo = vv[0];
    hi = vv[0];
    for (int k = 1; k < 3; k++) begin
      if (vv[k] < lo) lo = vv[k];
      if (vv[k] > hi) hi = vv[k];
    end
    for (int k = 0; k < 3; k++) begin
      b = (k == 2) ? 0 : k + 1;
      emin[k] = (vv[k] < vv[b]) ? vv[k] : vv[b];
      emax[k] = (vv[k] < vv[b]) ? vv[b] : vv[k];
      on_e[k] = (vv[k] == vv[b]) && (vv[k] == lv);
      cr_e[k] = (lv <= emax[k]) && (lv > emin[k]);
    end
    s2_meta_nxt = '0;
    nfound = 1'b0;
    stop   = 1'b0;
    c[0] = 2'd0;
    c[1] = 2'd0;
    ea = 2'd0;
    eb = 2'd1;
    if (!(lv < lo || lv > hi || lo == hi)) begin
      for (int k = 0; k < 3; k++) begin
        b = (k == 2) ? 0 : k + 1;
        if (!stop) begin
          if (on_e[k]) begin
            s2_meta_nxt.seg   = 1'b1;
            s2_meta_nxt.along = 1'b1;
            ea = 2'(k);
            eb = 2'(b);
            stop = 1'b1;
          end else if (cr_e[k]) begin
            if (!nfound) begin
              c[0] = 2'(k);
              nfound = 1'b1;
            end else begin
              c[1] = 2'(k);
              s2_meta_nxt.seg = 1'b1;
              stop = 1'b1;
            end
          end
        end
      end
    end
    s2_meta_nxt.sx = xx[ea];
    s2_meta_nxt.sy = yy[ea];
    s2_meta_nxt.ex = xx[eb];
    s2_meta_nxt.ey = yy[eb];
    for (int j = 0; j < 2; j++) begin
      cn[j] = (c[j] == 2'd2) ? 2'd0 : c[j] + 2'd1;
      s2_cr_nxt[j].px = xx[c[j]];
      s2_cr_nxt[j].py = yy[c[j]];
      s2_cr_nxt[j].qx = xx[cn[j]];
      s2_cr_nxt[j].qy = yy[cn[j]];
      s2_cr_nxt[j].dq = DIFF_W'(lv) - DIFF_W'(vv[cn[j]]);
      s2_cr_nxt[j].dp = DIFF_W'(vv[c[j]]) - DIFF_W'(lv);
      s2_cr_nxt[j].dd = DIFF_W'(vv[c[j]]) - DIFF_W'(vv[cn[j]]);
    end
  end

  // Numerator sums, magnitudes and quotient signs for the dividers.
  always_comb begin
    logic signed [NUM_W-1:0] nx, ny;
    for (int j = 0; j < 2; j++) begin
      nx = NUM_W'(s3_pr_r[j].px) + NUM_W'(s3_pr_r[j].qx);
      ny = NUM_W'(s3_pr_r[j].py) + NUM_W'(s3_pr_r[j].qy);
      s4_nmag_nxt[2*j]   = nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
      s4_nmag_nxt[2*j+1] = ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
      s4_dmag_nxt[2*j]   = s3_pr_r[j].dd[DIFF_W-1] ? DIFF_W'(-s3_pr_r[j].dd)
                                                   : DIFF_W'(s3_pr_r[j].dd);
      s4_dmag_nxt[2*j+1] = s4_dmag_nxt[2*j];
      s4_neg_nxt[2*j]    = nx[NUM_W-1] ^ s3_pr_r[j].dd[DIFF_W-1];
      s4_neg_nxt[2*j+1]  = ny[NUM_W-1] ^ s3_pr_r[j].dd[DIFF_W-1];
    end
  end

  genvar g;
  generate
    for (g = 0; g < 4; g++) begin : g_div
      tcs_divider u_div (
        .clk     (clk),
        .en      (en),
        .num_mag (s4_nmag_r[g]),
        .den_mag (s4_dmag_r[g]),
        .neg     (s4_neg_r[g]),
        .quo     (quo[g])
      );
    end
  endgenerate

  always_comb begin
    out_data_nxt = '0;
    if (div_meta_r[DIV_STEPS-1].seg) begin
      out_data_nxt.segment_valid = 1'b1;
      if (div_meta_r[DIV_STEPS-1].along) begin
        out_data_nxt.along_edge = 1'b1;
        out_data_nxt.start_x    = div_meta_r[DIV_STEPS-1].sx;
        out_data_nxt.start_y    = div_meta_r[DIV_STEPS-1].sy;
        out_data_nxt.end_x      = div_meta_r[DIV_STEPS-1].ex;
        out_data_nxt.end_y      = div_meta_r[DIV_STEPS-1].ey;
      end else begin
        out_data_nxt.start_x = quo[0];
        out_data_nxt.start_y = quo[1];
        out_data_nxt.end_x   = quo[2];
        out_data_nxt.end_y   = quo[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      div_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        level_r <= cfg_data;
      end
      if (en) begin
        s1_vld_r    <= in_valid;
        s2_vld_r    <= s1_vld_r;
        s3_vld_r    <= s2_vld_r;
        s4_vld_r    <= s3_vld_r;
        div_vld_r   <= {div_vld_r[DIV_STEPS-2:0], s4_vld_r};
        out_valid_r <= div_vld_r[DIV_STEPS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r  <= in_data;
      s1_level_r <= level_r;
      s2_meta_r  <= s2_meta_nxt;
      s3_meta_r  <= s2_meta_r;
      s4_meta_r  <= s3_meta_r;
      for (int j = 0; j < 2; j++) begin
        s2_cr_r[j]    <= s2_cr_nxt[j];
        s3_pr_r[j].px <= s2_cr_r[j].px * s2_cr_r[j].dq;
        s3_pr_r[j].qx <= s2_cr_r[j].qx * s2_cr_r[j].dp;
        s3_pr_r[j].py <= s2_cr_r[j].py * s2_cr_r[j].dq;
        s3_pr_r[j].qy <= s2_cr_r[j].qy * s2_cr_r[j].dp;
        s3_pr_r[j].dd <= s2_cr_r[j].dd;
      end
      for (int j = 0; j < 4; j++) begin
        s4_nmag_r[j] <= s4_nmag_nxt[j];
        s4_dmag_r[j] <= s4_dmag_nxt[j];
        s4_neg_r[j]  <= s4_neg_nxt[j];
      end
      div_meta_r[0] <= s4_meta_r;
      for (int i = 1; i < DIV_STEPS; i++) begin
        div_meta_r[i] <= div_meta_r[i-1];
      end
      out_data_r <= out_data_nxt;
    end
  end

  a_along_needs_seg : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.along_edge || out_data.segment_valid))
    else $error("along_edge set without a segment");

  a_empty_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.segment_valid) |->
      (out_data.start_x == '0 && out_data.start_y == '0 &&
       out_data.end_x == '0 && out_data.end_y == '0))
    else $error("empty result carries coordinates");

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== rtl/tcs_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division of magnitudes, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module tcs_divider
  import tcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [NUM_W-1:0]         num_mag,
  input  logic [DIFF_W-1:0]        den_mag,
  input  logic                     neg,
  output logic signed [QUO_W-1:0]  quo
);

  logic [NUM_W-1:0]  rem_r [DIV_STEPS];
  logic [DIFF_W-1:0] den_r [DIV_STEPS];
  logic [QUO_W-1:0]  quo_r [DIV_STEPS];
  logic              neg_r [DIV_STEPS];

  logic [NUM_W-1:0]  rem_in [DIV_STEPS];
  logic [DIFF_W-1:0] den_in [DIV_STEPS];
  logic [QUO_W-1:0]  quo_in [DIV_STEPS];
  logic              neg_in [DIV_STEPS];
  logic [NUM_W-1:0]  rem_nxt [DIV_STEPS];
  logic [QUO_W-1:0]  quo_nxt [DIV_STEPS];

  always_comb begin
    logic [NUM_W-1:0] trial;
    for (int i = 0; i < DIV_STEPS; i++) begin
      if (i == 0) begin
        rem_in[i] = num_mag;
        den_in[i] = den_mag;
        quo_in[i] = '0;
        neg_in[i] = neg;
      end else begin
        rem_in[i] = rem_r[i-1];
        den_in[i] = den_r[i-1];
        quo_in[i] = quo_r[i-1];
        neg_in[i] = neg_r[i-1];
      end
      trial = NUM_W'(den_in[i]) << (DIV_STEPS - 1 - i);
      rem_nxt[i] = rem_in[i];
      quo_nxt[i] = quo_in[i];
      if (rem_in[i] >= trial) begin
        rem_nxt[i] = rem_in[i] - trial;
        quo_nxt[i][DIV_STEPS-1-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem_r[i] <= rem_nxt[i];
        den_r[i] <= den_in[i];
        quo_r[i] <= quo_nxt[i];
        neg_r[i] <= neg_in[i];
      end
    end
  end

  assign quo = neg_r[DIV_STEPS-1] ? -$signed(quo_r[DIV_STEPS-1])
                                  : $signed(quo_r[DIV_STEPS-1]);

endmodule

// ===== tb/tb_triangle_contour_segment.sv =====
// ----------------------------------------------------------------------------
// Triangle contour segment testbench
// Drives triangles at several contour levels, predicts each segment from the
// marching triangles rule and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_triangle_contour_segment;
  import tcs_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tcs_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tcs_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic signed [VALUE_W-1:0] cfg_data = '0;

  logic signed [VALUE_W-1:0] level_q = '0;
  tcs_out_t segment_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  triangle_contour_segment u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic signed [15:0] crossing(longint p, longint q, longint vp, longint vq,
                                                  longint lv);
    longint num;
    num = p * (lv - vq) + q * (vp - lv);
    return 16'(num / (vp - vq));
  endfunction

  function automatic tcs_out_t predict_segment(tcs_in_t t, logic signed [31:0] lvl);
    tcs_out_t r;
    longint x[3], y[3], v[3];
    longint lo, hi, lv, emin, emax;
    int found, a, b;
    r = '0;
    found = 0;
    lv = lvl;
    x[0] = t.vertex_a_x; y[0] = t.vertex_a_y; v[0] = t.vertex_a_value;
    x[1] = t.vertex_b_x; y[1] = t.vertex_b_y; v[1] = t.vertex_b_value;
    x[2] = t.vertex_c_x; y[2] = t.vertex_c_y; v[2] = t.vertex_c_value;
    lo = v[0]; hi = v[0];
    for (int k = 1; k < 3; k++) begin
      if (v[k] < lo) lo = v[k];
      if (v[k] > hi) hi = v[k];
    end
    if (lv < lo || lv > hi || lo == hi) return '0;
    for (int k = 0; k < 3; k++) begin
      a = k;
      b = (k + 1) % 3;
      emin = v[a] < v[b] ? v[a] : v[b];
      emax = v[a] < v[b] ? v[b] : v[a];
      if (v[a] == v[b] && emax == lv) begin
        r.segment_valid = 1'b1;
        r.along_edge = 1'b1;
        r.start_x = 16'(x[a]); r.start_y = 16'(y[a]);
        r.end_x = 16'(x[b]); r.end_y = 16'(y[b]);
        return r;
      end
      if (lv <= emax && lv > emin) begin
        found++;
        if (found == 1) begin
          r.start_x = crossing(x[a], x[b], v[a], v[b], lv);
          r.start_y = crossing(y[a], y[b], v[a], v[b], lv);
        end else begin
          r.end_x = crossing(x[a], x[b], v[a], v[b], lv);
          r.end_y = crossing(y[a], y[b], v[a], v[b], lv);
          r.segment_valid = 1'b1;
          return r;
        end
      end
    end
    return '0;
  endfunction

  always @(posedge clk) begin
    tcs_out_t exp_seg;
    if (rst_n && out_valid && !out_stall) begin
      if (segment_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        exp_seg = segment_q.pop_front();
        if (exp_seg.segment_valid !== out_data.segment_valid ||
            exp_seg.along_edge !== out_data.along_edge ||
            exp_seg.start_x !== out_data.start_x || exp_seg.start_y !== out_data.start_y ||
            exp_seg.end_x !== out_data.end_x || exp_seg.end_y !== out_data.end_y) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_seg, out_data);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_triangle(tcs_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    segment_q.push_back(predict_segment(t, level_q));
  endtask

  task automatic drain_pipeline();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (segment_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic write_level(logic signed [31:0] lvl);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_data <= lvl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    level_q = lvl;
  endtask

  function automatic tcs_in_t make_triangle(logic signed [31:0] va, logic signed [31:0] vb,
                                            logic signed [31:0] vc);
    tcs_in_t t;
    t = '0;
    t.vertex_a_x = 16'($urandom); t.vertex_a_y = 16'($urandom);
    t.vertex_b_x = 16'($urandom); t.vertex_b_y = 16'($urandom);
    t.vertex_c_x = 16'($urandom); t.vertex_c_y = 16'($urandom);
    t.vertex_a_value = va; t.vertex_b_value = vb; t.vertex_c_value = vc;
    return t;
  endfunction

  function automatic logic signed [31:0] near_level(logic signed [31:0] lvl);
    longint d;
    case ($urandom_range(5))
      0: return lvl;
      1: return 32'($urandom);
      2: return 32'sh7fffffff;
      3: return 32'sh80000000;
      default: begin
        d = longint'(lvl) + $signed($urandom_range(200)) - 100;
        if (d > 64'sh7fffffff || d < -64'sh80000000) return lvl;
        return 32'(d);
      end
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] l;
    tcs_in_t t;
    l = level_q;
    send_triangle(make_triangle(l - 5, l + 5, l + 9));
    send_triangle(make_triangle(l, l, l + 7));
    send_triangle(make_triangle(l - 3, l, l));
    send_triangle(make_triangle(l, l - 2, l));
    send_triangle(make_triangle(l, l, l));
    send_triangle(make_triangle(l + 1, l + 2, l + 3));
    send_triangle(make_triangle(l - 4, l - 2, l - 1));
    send_triangle(make_triangle(l - 4, l, l - 1));
    send_triangle(make_triangle(l + 4, l, l + 1));
    send_triangle(make_triangle(l - 8, l + 1, l));
    t = make_triangle(32'sh80000000, 32'sh7fffffff, l);
    t.vertex_a_x = 16'sh8000; t.vertex_b_x = 16'sh7fff;
    t.vertex_a_y = 16'sh7fff; t.vertex_b_y = 16'sh8000;
    send_triangle(t);
    t = make_triangle(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    t = '1;
    send_triangle(t);
    send_triangle('0);
  endtask

  task automatic test_random(int count);
    logic signed [31:0] va, vb, vc;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        send_triangle(make_triangle(32'($urandom), 32'($urandom), 32'($urandom)));
      end else begin
        va = near_level(level_q);
        vb = near_level(level_q);
        vc = near_level(level_q);
        send_triangle(make_triangle(va, vb, vc));
      end
    end
  endtask

  task automatic test_levels();
    logic signed [31:0] levels[5];
    int pcts[4][2];
    levels = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sh00018000, 32'shfffe8000};
    pcts = '{'{0, 0}, '{69, 0}, '{0, 69}, '{33, 33}};
    foreach (levels[i]) begin
      write_level(levels[i]);
      send_idle_pct = 0;
      stall_pct = 0;
      test_directed();
      foreach (pcts[p]) begin
        send_idle_pct = pcts[p][0];
        stall_pct = pcts[p][1];
        test_random(80);
      end
    end
    write_level(32'($urandom));
    test_random(80);
    drain_pipeline();
    test_random(20);
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_levels();
    drain_pipeline();
    if (errors == 0 && segment_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
